// ----- design/sfr_pkg.sv -----
package sfr_pkg;

  // Receiver phase, one-hot
  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_FLAG = 5'b00010,
    PH_ADDR = 5'b00100,
    PH_CTRL = 5'b01000,
    PH_HCS  = 5'b10000
  } phase_e;

  // Configuration register indexes
  localparam logic [1:0] CFG_EXPECT_KIND = 2'd0;
  localparam logic [1:0] CFG_FLAG_BYTE   = 2'd1;
  localparam logic [1:0] CFG_ADDR_BYTE   = 2'd2;

  // expect_kind modes
  localparam logic [1:0] MODE_UA   = 2'd0;
  localparam logic [1:0] MODE_DISC = 2'd1;
  localparam logic [1:0] MODE_ACK  = 2'd2;

  // Frame kinds
  localparam logic [1:0] KIND_UA   = 2'd0;
  localparam logic [1:0] KIND_DISC = 2'd1;
  localparam logic [1:0] KIND_RR   = 2'd2;
  localparam logic [1:0] KIND_REJ  = 2'd3;

  // Control byte codes
  localparam logic [7:0] CTL_UA   = 8'h06;
  localparam logic [7:0] CTL_DISC = 8'h0A;
  localparam logic [7:0] CTL_RR0  = 8'h01;
  localparam logic [7:0] CTL_RR1  = 8'h11;
  localparam logic [7:0] CTL_REJ0 = 8'h05;
  localparam logic [7:0] CTL_REJ1 = 8'h15;

  // Register reset values
  localparam logic [1:0] EXPECT_KIND_RST = MODE_UA;
  localparam logic [7:0] FLAG_BYTE_RST   = 8'h5C;
  localparam logic [7:0] ADDR_BYTE_RST   = 8'h03;

  // Control decode result
  typedef struct packed {
    logic       hit;
    logic [1:0] kind;
  } ctl_dec_t;

endpackage

// ----- design/sfr_ctl_decode.sv -----
module sfr_ctl_decode (
  input  logic [7:0]       ctl_byte_i,
  input  logic [1:0]       expect_kind_i,
  output sfr_pkg::ctl_dec_t dec_o
);

  always_comb begin
    dec_o = '0;
    unique case (expect_kind_i)
      sfr_pkg::MODE_UA: begin
        dec_o.hit  = (ctl_byte_i == sfr_pkg::CTL_UA);
        dec_o.kind = sfr_pkg::KIND_UA;
      end
      sfr_pkg::MODE_DISC: begin
        dec_o.hit  = (ctl_byte_i == sfr_pkg::CTL_DISC);
        dec_o.kind = sfr_pkg::KIND_DISC;
      end
      sfr_pkg::MODE_ACK: begin
        case (ctl_byte_i) inside
          sfr_pkg::CTL_RR0, sfr_pkg::CTL_RR1: begin
            dec_o.hit  = 1'b1;
            dec_o.kind = sfr_pkg::KIND_RR;
          end
          sfr_pkg::CTL_REJ0, sfr_pkg::CTL_REJ1: begin
            dec_o.hit  = 1'b1;
            dec_o.kind = sfr_pkg::KIND_REJ;
          end
          default: dec_o = '0;
        endcase
      end
      default: dec_o = '0; // unused mode takes no control byte
    endcase
  end

endmodule

// ----- design/supervision_frame_receiver_unit.sv -----
// A byte's result is registered and presented in the cycle after its request is taken.
// Throughput: one byte per cycle while no held result waits on res_ready_i; the
//   phase register takes a single next-state step per accepted byte.
// The byte side stays ready while the result register is empty or being drained.
// Reset (rst_ni low, asynchronous): phase to idle, no result pending,
//   expect_kind 0, flag byte 0x5C, address byte 0x03.
module supervision_frame_receiver_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration write channel
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  // received byte channel
  input  logic       rx_valid_i,
  output logic       rx_ready_o,
  input  logic [7:0] rx_byte_i,
  // result channel
  output logic       res_valid_o,
  input  logic       res_ready_i,
  output logic       frame_done_o,
  output logic [1:0] frame_kind_o,
  output logic       rejected_o
);

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic [1:0] expect_kind_q;
  logic [7:0] flag_byte_q;
  logic [7:0] addr_byte_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_kind_q <= sfr_pkg::EXPECT_KIND_RST;
      flag_byte_q   <= sfr_pkg::FLAG_BYTE_RST;
      addr_byte_q   <= sfr_pkg::ADDR_BYTE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        sfr_pkg::CFG_EXPECT_KIND: expect_kind_q <= cfg_data_i[1:0];
        sfr_pkg::CFG_FLAG_BYTE:   flag_byte_q   <= cfg_data_i;
        sfr_pkg::CFG_ADDR_BYTE:   addr_byte_q   <= cfg_data_i;
        default: ; // index beyond the register list is dropped
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Control byte decode: once for the byte on the input (control
  // phase), once for the held control at the closing flag. The
  // held one is decoded against the mode in force at close time.
  // ---------------------------------------------------------------
  sfr_pkg::ctl_dec_t rx_dec;
  sfr_pkg::ctl_dec_t held_dec;
  logic [7:0]        held_ctl_q;
  logic [7:0]        held_ctl_d;

  sfr_ctl_decode u_rx_dec (
    .ctl_byte_i   (rx_byte_i),
    .expect_kind_i(expect_kind_q),
    .dec_o        (rx_dec)
  );

  sfr_ctl_decode u_held_dec (
    .ctl_byte_i   (held_ctl_q),
    .expect_kind_i(expect_kind_q),
    .dec_o        (held_dec)
  );

  // ---------------------------------------------------------------
  // Handshake: result register is the only stage; a new byte goes
  // in whenever that register is empty or empties in the same cycle.
  // ---------------------------------------------------------------
  logic res_valid_q;
  logic rx_fire;

  assign rx_ready_o = !res_valid_q || res_ready_i;
  assign rx_fire    = rx_valid_i && rx_ready_o;

  // ---------------------------------------------------------------
  // Frame recogniser
  // ---------------------------------------------------------------
  sfr_pkg::phase_e phase_q;
  sfr_pkg::phase_e phase_d;
  sfr_pkg::phase_e mismatch_ph;
  logic            done_d;
  logic [1:0]      kind_d;
  logic            rej_d;
  logic [7:0]      hcs_exp;

  // A flag in place of the expected field restarts the frame.
  assign mismatch_ph = (rx_byte_i == flag_byte_q) ? sfr_pkg::PH_FLAG : sfr_pkg::PH_IDLE;
  assign hcs_exp     = addr_byte_q ^ held_ctl_q;

  always_comb begin
    phase_d    = phase_q;
    held_ctl_d = held_ctl_q;
    done_d     = 1'b0;
    kind_d     = sfr_pkg::KIND_UA;
    rej_d      = 1'b0;
    unique case (phase_q)
      sfr_pkg::PH_IDLE: begin
        phase_d = mismatch_ph;
      end
      sfr_pkg::PH_FLAG: begin
        // expected field wins over flag when the two coincide
        phase_d = (rx_byte_i == addr_byte_q) ? sfr_pkg::PH_ADDR : mismatch_ph;
      end
      sfr_pkg::PH_ADDR: begin
        if (rx_dec.hit) begin
          held_ctl_d = rx_byte_i;
          phase_d    = sfr_pkg::PH_CTRL;
        end else begin
          phase_d = mismatch_ph;
        end
      end
      sfr_pkg::PH_CTRL: begin
        phase_d = (rx_byte_i == hcs_exp) ? sfr_pkg::PH_HCS : mismatch_ph;
      end
      sfr_pkg::PH_HCS: begin
        // closing flag; receiver rearms to idle either way
        if ((rx_byte_i == flag_byte_q) && held_dec.hit) begin
          done_d = 1'b1;
          kind_d = held_dec.kind;
          rej_d  = (held_dec.kind == sfr_pkg::KIND_REJ);
        end
        phase_d = sfr_pkg::PH_IDLE;
      end
      default: begin
        phase_d = mismatch_ph;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= sfr_pkg::PH_IDLE;
      held_ctl_q <= 8'h00;
    end else if (rx_fire) begin
      phase_q    <= phase_d;
      held_ctl_q <= held_ctl_d;
    end
  end

  // ---------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------
  logic       frame_done_q;
  logic [1:0] frame_kind_q;
  logic       rejected_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (rx_fire) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_fire) begin
      frame_done_q <= done_d;
      frame_kind_q <= kind_d;
      rejected_q   <= rej_d;
    end
  end

  assign res_valid_o  = res_valid_q;
  assign frame_done_o = frame_done_q;
  assign frame_kind_o = frame_kind_q;
  assign rejected_o   = rejected_q;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  a_phase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(phase_q))
    else $error("phase register not one-hot");

  a_done_only_from_hcs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rx_fire && phase_q != sfr_pkg::PH_HCS) |=> !frame_done_o)
    else $error("frame completed outside the check-passed phase");

  a_rearm_after_hcs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rx_fire && phase_q == sfr_pkg::PH_HCS) |=> (phase_q == sfr_pkg::PH_IDLE))
    else $error("receiver did not rearm after closing byte");

  a_rej_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && rejected_o) |-> (frame_done_o && frame_kind_o == sfr_pkg::KIND_REJ))
    else $error("rejection flagged on a non-REJ result");

  a_idle_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !frame_done_o) |-> (frame_kind_o == sfr_pkg::KIND_UA && !rejected_o))
    else $error("kind fields set without a completed frame");

endmodule
